[rtl/core/bfc_pkg.sv]
// ----------------------------------------------------------------------------
// bfc_pkg
// Types, codes and defaults shared by the byte FIFO with frame count.
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int FILL_W        = 9;
    localparam logic [7:0] DELIM_RESET = 8'd10;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0]        data_out;
        logic              ok;
        logic [FILL_W-1:0] fill_level;
        logic              is_empty;
        logic              is_full;
        logic              frame_ready;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic frame_upd;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic pop_ok;
        logic out_free;
    } stat_t;

endpackage

[rtl/core/bfc_ctrl.sv]
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer: accept a word, execute it, check a popped byte for the delimiter, load the result.
// ----------------------------------------------------------------------------
module bfc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bfc_pkg::stat_t stat,
    output bfc_pkg::cmd_t  cmd
);

    bfc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            bfc_pkg::ST_IDLE: begin
                s_ready  = aresetn;
                cmd.take = s_valid && aresetn;
                if (s_valid) begin
                    state_next = bfc_pkg::ST_EXEC;
                end
            end
            bfc_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.pop_ok ? bfc_pkg::ST_READ : bfc_pkg::ST_LOAD;
            end
            bfc_pkg::ST_READ: begin
                cmd.frame_upd = 1'b1;
                state_next    = bfc_pkg::ST_LOAD;
            end
            bfc_pkg::ST_LOAD: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = bfc_pkg::ST_IDLE;
                end
            end
            default: state_next = bfc_pkg::ST_IDLE;
        endcase
    end

endmodule

[rtl/core/bfc_datapath.sv]
// ----------------------------------------------------------------------------
// bfc_datapath
// Byte store, pointers, frame counters, delimiter and result register.
// ----------------------------------------------------------------------------
module bfc_datapath #(
    parameter int DEPTH = bfc_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bfc_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bfc_pkg::out_word_t m_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  bfc_pkg::cmd_t      cmd,
    output bfc_pkg::stat_t     stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam int FW = bfc_pkg::FILL_W;

    logic [7:0]          mem [DEPTH];
    bfc_pkg::in_word_t   item_reg;
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [7:0]          fput_reg, fput_next;
    logic [7:0]          ftake_reg, ftake_next;
    logic [7:0]          delim_reg;
    logic [7:0]          rdata_reg;
    logic                ok_reg, ok_next;
    logic                popped_reg;
    logic                m_valid_reg;
    bfc_pkg::out_word_t  m_data_reg;
    logic                mem_we, mem_re;
    logic [PW-1:0]       fill;
    logic [PW+FW-1:0]    fill_ext;
    logic                empty, full;

    assign fill     = wr_ptr_reg - rd_ptr_reg;
    assign fill_ext = {{FW{1'b0}}, fill};
    assign empty    = (fill == '0);
    assign full     = (fill == PW'(DEPTH));

    assign stat.pop_ok   = (item_reg.func == bfc_pkg::FUNC_POP) && !empty;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fput_next   = fput_reg;
        ftake_next  = ftake_reg;
        ok_next     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (cmd.exec) begin
            unique case (item_reg.func)
                bfc_pkg::FUNC_PUSH: begin
                    if (!full) begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + PW'(1);
                        ok_next     = 1'b1;
                        if (item_reg.data_in == delim_reg) begin
                            fput_next = fput_reg + 8'd1;
                        end
                    end
                end
                bfc_pkg::FUNC_POP: begin
                    if (!empty) begin
                        mem_re      = 1'b1;
                        rd_ptr_next = rd_ptr_reg + PW'(1);
                        ok_next     = 1'b1;
                    end
                end
                bfc_pkg::FUNC_FLUSH: begin
                    rd_ptr_next = wr_ptr_reg;
                    ftake_next  = fput_reg;
                    ok_next     = 1'b1;
                end
                default: ok_next = 1'b0;
            endcase
        end
        if (cmd.frame_upd && (rdata_reg == delim_reg)) begin
            ftake_next = ftake_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_ptr_reg[AW-1:0]] <= item_reg.data_in;
        end
        if (mem_re) begin
            rdata_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            ok_reg     <= ok_next;
            popped_reg <= mem_re;
        end
        if (cmd.load) begin
            m_data_reg.data_out    <= popped_reg ? rdata_reg : 8'd0;
            m_data_reg.ok          <= ok_reg;
            m_data_reg.fill_level  <= fill_ext[FW-1:0];
            m_data_reg.is_empty    <= empty;
            m_data_reg.is_full     <= full;
            m_data_reg.frame_ready <= (fput_reg != ftake_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fput_reg    <= '0;
            ftake_reg   <= '0;
            delim_reg   <= bfc_pkg::DELIM_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fput_reg   <= fput_next;
            ftake_reg  <= ftake_next;
            if (cfg_we) begin
                delim_reg <= cfg_wdata;
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/core/byte_fifo_with_frame_count.sv]
// ----------------------------------------------------------------------------
// byte_fifo_with_frame_count
// Byte FIFO with delimiter-based frame counters, one operation per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries an operation word (push, pop, flush) with valid/ready.
//   m_ channel returns exactly one result word per operation, in order.
//   cfg_we/cfg_wdata write the delimiter byte; write only while idle.
// Steps: after accept, each word is executed and its result then loaded;
//   a successful pop adds a read step, as the byte store read is registered.
// The sequencer works on one word at a time: it accepts the next word
//   only after the result of the current one is loaded.
// The result register lets the next word be accepted while a result waits;
// if the receiver stalls, the following word stops in its load step until
// the result register frees, and s_ready stays low meanwhile.
// Reset clears pointers, frame counters and m_valid, and sets the
// delimiter to 10; store contents are not cleared and there is no
// clearing pass.
// ----------------------------------------------------------------------------
module byte_fifo_with_frame_count #(
    parameter int DEPTH = bfc_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bfc_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bfc_pkg::out_word_t m_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);

    bfc_pkg::cmd_t  cmd;
    bfc_pkg::stat_t stat;

    bfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bfc_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[rtl/core/bfc_checker.sv]
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level assertions for the byte FIFO with frame count.
// ----------------------------------------------------------------------------
module bfc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bfc_pkg::out_word_t m_data
);

    a_one_word_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while one is in progress");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    a_data_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.data_out != 8'd0)) |-> m_data.ok)
        else $error("nonzero data_out on a failed operation");

    a_empty_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_empty && m_data.is_full))
        else $error("empty and full flagged together");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind byte_fifo_with_frame_count bfc_checker u_bfc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
